>>> design/pae_pkg.sv
// shared constants and register codes for the packet airtime estimator
// no dependencies
package pae_pkg;

	localparam int unsigned MAX_PAYLOAD_DEF = 255;

	localparam int unsigned BW_W   = 20;
	localparam int unsigned SF_W   = 4;
	localparam int unsigned CR_W   = 4;
	localparam int unsigned PRE_W  = 8;
	localparam int unsigned LEN_W  = 9;
	localparam int unsigned MS_W   = 32;
	localparam int unsigned IDX_W  = 3;
	localparam int unsigned DATA_W = 20;

	localparam logic [BW_W-1:0] BW_MAX = 20'd1000000;

	// payload block division
	localparam int unsigned BLK_N   = 12;
	localparam int unsigned BLK_DW  = 6;
	localparam int unsigned BLK_QW  = 7;
	// quarter symbol count and millisecond division
	localparam int unsigned Q_W     = 13;
	localparam int unsigned Q250_W  = 21;
	localparam int unsigned MS_N    = 34;

	localparam logic [IDX_W-1:0] REG_BW  = 3'd0;
	localparam logic [IDX_W-1:0] REG_SF  = 3'd1;
	localparam logic [IDX_W-1:0] REG_CR  = 3'd2;
	localparam logic [IDX_W-1:0] REG_PRE = 3'd3;
	localparam logic [IDX_W-1:0] REG_CRC = 3'd4;

endpackage

>>> design/pae_div_cell.sv
// one restoring division step: one quotient bit per cell
// generic, no package use
module pae_div_cell #(
	parameter int unsigned N  = 8,
	parameter int unsigned DW = 8,
	parameter int unsigned SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          valid_in,
	input  logic [DW-1:0] rem_in,
	input  logic [N-1:0]  work_in,
	input  logic [SW-1:0] side_in,
	input  logic [DW-1:0] div,
	output logic          valid_q,
	output logic [DW-1:0] rem_q,
	output logic [N-1:0]  work_q,
	output logic [SW-1:0] side_q
);
	logic [DW:0] trial;
	logic [DW:0] diff;
	logic        ge;

	assign trial = {rem_in, work_in[N-1]};
	assign diff  = trial - {1'b0, div};
	assign ge    = trial >= {1'b0, div};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= ge ? diff[DW-1:0] : trial[DW-1:0];
			work_q <= {work_in[N-2:0], ge};
			side_q <= side_in;
		end
	end
endmodule

>>> design/pae_div_chain.sv
// row of division cells, a beat moves one cell per enabled cycle
// uses pae_div_cell
module pae_div_chain #(
	parameter int unsigned N  = 8,
	parameter int unsigned DW = 8,
	parameter int unsigned SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          valid_in,
	input  logic [N-1:0]  dividend,
	input  logic [SW-1:0] side_in,
	input  logic [DW-1:0] div,
	output logic          valid_out,
	output logic [N-1:0]  quotient,
	output logic [SW-1:0] side_out
);
	logic          v   [N+1];
	logic [DW-1:0] rem [N+1];
	logic [N-1:0]  wrk [N+1];
	logic [SW-1:0] sd  [N+1];

	assign v[0]   = valid_in;
	assign rem[0] = '0;
	assign wrk[0] = dividend;
	assign sd[0]  = side_in;

	for (genvar i = 0; i < N; i++) begin : g_cell
		pae_div_cell #(.N(N), .DW(DW), .SW(SW)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.valid_in(v[i]), .rem_in(rem[i]), .work_in(wrk[i]), .side_in(sd[i]),
			.div(div),
			.valid_q(v[i+1]), .rem_q(rem[i+1]), .work_q(wrk[i+1]), .side_q(sd[i+1])
		);
	end

	assign valid_out = v[N];
	assign quotient  = wrk[N];
	assign side_out  = sd[N];
endmodule

>>> design/packet_airtime_estimator_core.sv
// packet airtime estimator top: config registers, front stages, two division rows
// uses pae_pkg and pae_div_chain
// path from accepted beat to result: input register, block division row, stages s2 to s4, millisecond division row
// throughput: one beat per cycle unless stalled; the two cell rows each retire one beat a cycle
// whole pipeline stalls together only while the result is held unaccepted
// reset clears valid bits and loads the default radio settings
module packet_airtime_estimator_core #(
	parameter int unsigned MAX_PAYLOAD = pae_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [pae_pkg::IDX_W-1:0]   cfg_index,
	input  logic [pae_pkg::DATA_W-1:0]  cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [pae_pkg::LEN_W-1:0]   payload_bytes,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [pae_pkg::MS_W-1:0]    toa_ms
);
	import pae_pkg::*;

	logic [BW_W-1:0]  bw_q;
	logic [SF_W-1:0]  sf_q;
	logic [CR_W-1:0]  cr_q;
	logic [PRE_W-1:0] pre_q;
	logic             crc_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bw_q  <= 20'd125000;
			sf_q  <= 4'd7;
			cr_q  <= 4'd5;
			pre_q <= 8'd8;
			crc_q <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_BW:  bw_q  <= cfg_data[BW_W-1:0];
				REG_SF:  sf_q  <= cfg_data[SF_W-1:0];
				REG_CR:  cr_q  <= cfg_data[CR_W-1:0];
				REG_PRE: pre_q <= cfg_data[PRE_W-1:0];
				REG_CRC: crc_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// settings-derived terms; the user must keep settings stable while beats are in flight, the block does not enforce it
	logic [21:0]       chips125;
	logic              ldro;
	logic [BLK_DW-1:0] den;
	logic              cfg_bad;

	assign chips125 = 22'd125 << sf_q;
	assign ldro     = chips125 >= {1'b0, bw_q, 1'b0};
	assign den      = {sf_q - {2'b00, ldro, 1'b0}, 2'b00};
	assign cfg_bad  = (sf_q < 4'd7) || (sf_q > 4'd12) || (bw_q == '0) ||
		(bw_q > BW_MAX) || (cr_q < 4'd5) || (cr_q > 4'd8);

	// numerator 8*len + 28 + 16*crc - 4*sf, signed
	logic signed [13:0] num;
	logic [BLK_N-1:0]   bdvd;
	logic               len_bad;

	assign num = $signed({2'b00, payload_bytes, 3'b000}) + 14'sd28 +
		$signed({9'd0, crc_q, 4'b0000}) - $signed({8'd0, sf_q, 2'b00});
	assign bdvd = (num > 14'sd0) ?
		BLK_N'(num[BLK_N-1:0] + {{(BLK_N-BLK_DW){1'b0}}, den} - 1'b1) : '0;
	assign len_bad = (payload_bytes == '0) || (payload_bytes > LEN_W'(MAX_PAYLOAD));

	logic             v_s1, inv_s1;
	logic [BLK_N-1:0] bdvd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			inv_s1  <= len_bad || cfg_bad;
			bdvd_s1 <= bdvd;
		end
	end

	logic             va;
	logic [BLK_N-1:0] blocks_w;
	logic             inva;

	pae_div_chain #(.N(BLK_N), .DW(BLK_DW), .SW(1)) u_blk (
		.clk(clk), .arst_n(arst_n), .en(en),
		.valid_in(v_s1), .dividend(bdvd_s1), .side_in(inv_s1), .div(den),
		.valid_out(va), .quotient(blocks_w), .side_out(inva)
	);

	// quarter symbols, then scaling by 250 and 2^sf with ceiling bias
	logic [10:0]       bcr;
	logic              v_s2, inv_s2, v_s3, inv_s3, v_s4, inv_s4;
	logic [Q_W-1:0]    q_s2;
	logic [Q250_W-1:0] q250_s3;
	logic [MS_N-1:0]   dvd_s4;

	assign bcr = blocks_w[BLK_QW-1:0] * cr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s2 <= va;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			inv_s2  <= inva;
			q_s2    <= {3'b000, pre_q, 2'b00} + 13'd49 + {bcr, 2'b00};
			inv_s3  <= inv_s2;
			q250_s3 <= q_s2 * 8'd250;
			inv_s4  <= inv_s3;
			dvd_s4  <= ({{(MS_N-Q250_W){1'b0}}, q250_s3} << sf_q) +
				{{(MS_N-BW_W){1'b0}}, bw_q} - 1'b1;
		end
	end

	logic            vb, invb;
	logic [MS_N-1:0] ms_w;

	pae_div_chain #(.N(MS_N), .DW(BW_W), .SW(1)) u_ms (
		.clk(clk), .arst_n(arst_n), .en(en),
		.valid_in(v_s4), .dividend(dvd_s4), .side_in(inv_s4), .div(bw_q),
		.valid_out(vb), .quotient(ms_w), .side_out(invb)
	);

	assign out_valid = vb;
	assign toa_ms    = invb ? '0 : ms_w[MS_W-1:0];
endmodule
